### design/lcs_pkg.sv
// shared types and constants of the load cell strain conditioner
// no dependencies
package lcs_pkg;

  localparam int RAW_W    = 24;
  localparam int STRAIN_W = 32;
  localparam int GAIN_W   = 24;
  localparam int ALPHA_W  = 17;
  localparam int CMD_W    = 2;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  typedef logic signed [RAW_W-1:0]    raw_t;
  typedef logic signed [STRAIN_W-1:0] strain_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [ALPHA_W-1:0]         alpha_t;
  typedef logic [CFG_W-1:0]           cfg_data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_MEASURE = 2'd0,
    CMD_TARE    = 2'd1,
    CMD_SEED    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRAIN_GAIN  = 1'b0,
    REG_FILTER_ALPHA = 1'b1
  } reg_idx_t;

endpackage

### design/lcs_in_if.sv
// input sample channel: valid/ready handshake plus one sample beat
// depends on lcs_pkg
interface lcs_in_if;
  import lcs_pkg::*;

  logic valid;
  logic ready;
  raw_t raw_sample;
  logic sample_valid;
  logic last_in_group;
  cmd_t command;

  modport source (output valid, raw_sample, sample_valid, last_in_group, command,
                  input ready);
  modport sink (input valid, raw_sample, sample_valid, last_in_group, command,
                output ready);
endinterface

### design/lcs_out_if.sv
// result channel: valid/ready handshake plus one result beat
// depends on lcs_pkg
interface lcs_out_if;
  import lcs_pkg::*;

  logic    valid;
  logic    ready;
  raw_t    average_raw;
  strain_t strain_value;
  strain_t filtered_value;
  logic    none_valid;

  modport source (output valid, average_raw, strain_value, filtered_value, none_valid,
                  input ready);
  modport sink (input valid, average_raw, strain_value, filtered_value, none_valid,
                output ready);
endinterface

### design/load_cell_strain_conditioner_top.sv
// load cell strain conditioner: group averaging, tare, Q24.8 strain, low-pass filter
// non-last beats are taken one per cycle; a last beat drops ready while the bit-serial
// divider (skipped for an empty group) and average step run, and for measure and seed
// also the strain, filter (measure only) and result steps; the result waits on out ready
// active-high sync reset clears group, tare, filter, handshakes; presets gain and alpha
// depends on lcs_pkg, lcs_in_if, lcs_out_if
module load_cell_strain_conditioner_top #(
  parameter int MAX_GROUP   = 255,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  lcs_pkg::cfg_data_t          cfg_wdata,
  lcs_in_if.sink                      in_ch,
  lcs_out_if.source                   out_ch
);
  import lcs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int MAG_W  = SAMPLE_BITS - 1 + CNT_W;
  localparam int SUM_W  = MAG_W + 1;
  localparam int IT_W   = $clog2(MAG_W + 1);
  localparam int DIFF_W = RAW_W + 1;
  localparam int FD_W   = STRAIN_W + 1;
  localparam int MA_W   = FD_W + 1;
  localparam int MB_W   = GAIN_W + 1;
  localparam int PROD_W = MA_W + MB_W;

  typedef enum logic [2:0] {
    S_ACC, S_DIV, S_AVG, S_MUL_S, S_STRAIN, S_MUL_F, S_FILT, S_RESULT
  } state_t;

  state_t                    state;
  gain_t                     strain_gain;
  alpha_t                    filter_alpha;
  logic signed [SUM_W-1:0]   group_sum;
  logic [CNT_W-1:0]          valid_count;
  raw_t                      tare_offset;
  strain_t                   filter_state;

  logic [MAG_W-1:0]          div_q;
  logic [CNT_W-1:0]          div_rem;
  logic [CNT_W-1:0]          divisor;
  logic [IT_W-1:0]           div_cnt;
  logic                      sum_neg;
  logic                      none;
  cmd_t                      cmd;
  raw_t                      avg;
  strain_t                   strain;
  logic signed [PROD_W-1:0]  mul_p;

  logic                      out_valid;
  raw_t                      out_avg;
  strain_t                   out_strain;
  strain_t                   out_filt;
  logic                      out_none;

  logic                      take;
  logic                      add_ok;
  logic signed [SUM_W-1:0]   sample_ext;
  logic signed [SUM_W-1:0]   sum_after;
  logic [CNT_W-1:0]          count_after;
  logic [MAG_W-1:0]          sum_mag;
  logic [CNT_W:0]            trial;
  logic                      trial_ge;
  logic [CNT_W:0]            trial_sub;
  logic signed [SUM_W-1:0]   q_signed;
  raw_t                      avg_calc;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [FD_W-1:0]    filt_d;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  mul_res;
  logic signed [PROD_W-1:0]  strain_shift;
  logic signed [PROD_W-1:0]  filt_step;
  logic signed [PROD_W-1:0]  filt_sum;
  strain_t                   strain_sat;
  strain_t                   filt_sat;

  function automatic strain_t sat32(input logic signed [PROD_W-1:0] v);
    strain_t r;
    if (v[PROD_W-1:STRAIN_W-1] == '0 || v[PROD_W-1:STRAIN_W-1] == '1) begin
      r = v[STRAIN_W-1:0];
    end else if (v[PROD_W-1]) begin
      r = {1'b1, {(STRAIN_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STRAIN_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_ch.ready           = (state == S_ACC);
  assign out_ch.valid          = out_valid;
  assign out_ch.average_raw    = out_avg;
  assign out_ch.strain_value   = out_strain;
  assign out_ch.filtered_value = out_filt;
  assign out_ch.none_valid     = out_none;

  // accumulate
  assign take        = in_ch.valid && in_ch.ready;
  assign sample_ext  = SUM_W'(signed'(in_ch.raw_sample[SAMPLE_BITS-1:0]));
  assign add_ok      = in_ch.sample_valid && (valid_count < CNT_W'(MAX_GROUP));
  assign sum_after   = add_ok ? group_sum + sample_ext : group_sum;
  assign count_after = add_ok ? valid_count + CNT_W'(1) : valid_count;
  assign sum_mag     = sum_after[SUM_W-1] ? MAG_W'(-sum_after) : MAG_W'(sum_after);

  // restoring divider, one quotient bit per cycle
  assign trial     = {div_rem, div_q[MAG_W-1]};
  assign trial_ge  = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  assign q_signed = sum_neg ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});
  assign avg_calc = none ? tare_offset : RAW_W'(q_signed);

  assign diff   = DIFF_W'(avg) - DIFF_W'(tare_offset);
  assign filt_d = FD_W'(strain) - FD_W'(filter_state);

  // shared multiplier
  always_comb begin
    if (state == S_MUL_S) begin
      mul_a = MA_W'(diff);
      mul_b = signed'({1'b0, strain_gain});
    end else begin
      mul_a = MA_W'(filt_d);
      mul_b = MB_W'(signed'({1'b0, filter_alpha}));
    end
  end
  assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign strain_shift = mul_p >>> 16;
  assign strain_sat   = sat32(strain_shift);
  assign filt_step    = (mul_p + PROD_W'(32768)) >>> 16;
  assign filt_sum     = PROD_W'(filter_state) + filt_step;
  assign filt_sat     = sat32(filt_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_ACC;
      strain_gain  <= GAIN_W'(31250);
      filter_alpha <= ALPHA_W'(36492);
      group_sum    <= '0;
      valid_count  <= '0;
      tare_offset  <= '0;
      filter_state <= '0;
      out_valid    <= 1'b0;
      div_cnt      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STRAIN_GAIN:  strain_gain <= cfg_wdata[GAIN_W-1:0];
          REG_FILTER_ALPHA: filter_alpha <= cfg_wdata[ALPHA_W-1] ? ALPHA_ONE
                                            : cfg_wdata[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACC: begin
          if (take) begin
            if (in_ch.last_in_group) begin
              group_sum   <= '0;
              valid_count <= '0;
              div_q       <= sum_mag;
              div_rem     <= '0;
              divisor     <= count_after;
              div_cnt     <= '0;
              sum_neg     <= sum_after[SUM_W-1];
              none        <= (count_after == '0);
              cmd         <= in_ch.command;
              state       <= (count_after == '0) ? S_AVG : S_DIV;
            end else begin
              group_sum   <= sum_after;
              valid_count <= count_after;
            end
          end
        end
        S_DIV: begin
          div_q   <= {div_q[MAG_W-2:0], trial_ge};
          div_rem <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
          div_cnt <= div_cnt + IT_W'(1);
          if (div_cnt == IT_W'(MAG_W - 1)) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          avg <= avg_calc;
          case (cmd)
            CMD_TARE: begin
              tare_offset <= avg_calc;
              state       <= S_ACC;
            end
            CMD_NONE: state <= S_ACC;
            default:  state <= S_MUL_S;
          endcase
        end
        S_MUL_S: begin
          mul_p <= mul_res;
          state <= S_STRAIN;
        end
        S_STRAIN: begin
          strain <= strain_sat;
          if (cmd == CMD_SEED) begin
            filter_state <= strain_sat;
            state        <= S_RESULT;
          end else begin
            state <= S_MUL_F;
          end
        end
        S_MUL_F: begin
          mul_p <= mul_res;
          state <= S_FILT;
        end
        S_FILT: begin
          filter_state <= filt_sat;
          state        <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_avg    <= avg;
            out_strain <= strain;
            out_filt   <= filter_state;
            out_none   <= none;
            state      <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

`ifndef SYNTH
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (take && in_ch.last_in_group) |=> !in_ch.ready)
    else $error("ready stayed high after a last beat");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rem < divisor))
    else $error("divider remainder out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CNT_W'(MAX_GROUP))
    else $error("valid count beyond group limit");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESULT)
    else $error("result raised outside the result step");
`endif

endmodule
